FILE: design/pd_controller_3d_clamped_smoothed_unit_macros.svh
// Assertion macros used by the checker module.
`ifndef PD_CONTROLLER_3D_CLAMPED_SMOOTHED_UNIT_MACROS_SVH
`define PD_CONTROLLER_3D_CLAMPED_SMOOTHED_UNIT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define PDC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a next-cycle implication on every clock edge outside reset.
`define PDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pdc3d_pkg.sv
package pdc3d_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned MagW  = 31;
  localparam int unsigned SmW   = 17;
  localparam int unsigned ProdW = 66;
  localparam int unsigned SqW   = 66;
  localparam logic [SqW-1:0] TinySq = 66'd42;
  localparam logic [SmW-1:0] OneQ16 = 17'd65536;

  localparam logic [1:0] RegPosGain = 2'd0;
  localparam logic [1:0] RegVelGain = 2'd1;
  localparam logic [1:0] RegMaxMag  = 2'd2;
  localparam logic [1:0] RegSmooth  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_D,
    ST_SUM,
    ST_SQ,
    ST_TEST,
    ST_SQRT,
    ST_SQRT_FIX,
    ST_DIV,
    ST_DIV_END,
    ST_SMOOTH,
    ST_SMOOTH_END,
    ST_OUT
  } state_t;

endpackage

FILE: design/pd_controller_3d_clamped_smoothed_unit.sv
// Three-axis PD controller with magnitude clamp and output smoothing, Q16.16.
// One item is handled at a time; a result waits in the output register while
// the next item is already accepted. Arithmetic is bit serial: the gain,
// axis square, max_magnitude square and smoothing products are shift-and-add
// loops of one multiplier bit per cycle (the clamp dividend is a parallel
// product), the square root retires two radicand bits per cycle, and the
// clamp division is restoring, one quotient bit per cycle. The square root
// and division run only when the clamp is hit, and smoothing only when
// smooth_factor is nonzero and a previous result exists. A result still held
// by out_stall when the next one is ready keeps the next one waiting in
// ST_OUT, with in_stall high, until the output register is free.
module pd_controller_3d_clamped_smoothed_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [31:0]               cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [31:0]        cur_pos_x,
  input  logic signed [31:0]        cur_pos_y,
  input  logic signed [31:0]        cur_pos_z,
  input  logic signed [31:0]        tgt_pos_x,
  input  logic signed [31:0]        tgt_pos_y,
  input  logic signed [31:0]        tgt_pos_z,
  input  logic signed [31:0]        cur_vel_x,
  input  logic signed [31:0]        cur_vel_y,
  input  logic signed [31:0]        cur_vel_z,
  input  logic signed [31:0]        tgt_vel_x,
  input  logic signed [31:0]        tgt_vel_y,
  input  logic signed [31:0]        tgt_vel_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        drive_x,
  output logic signed [31:0]        drive_y,
  output logic signed [31:0]        drive_z,
  output logic                      was_limited
);

  // configuration
  logic signed [31:0] pos_gain, vel_gain;
  logic [30:0] max_magnitude;
  logic [16:0] smooth_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_gain <= '0;
      vel_gain <= '0;
      max_magnitude <= '0;
      smooth_factor <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pdc3d_pkg::RegPosGain: pos_gain <= cfg_data;
        pdc3d_pkg::RegVelGain: vel_gain <= cfg_data;
        pdc3d_pkg::RegMaxMag:  max_magnitude <= cfg_data[30:0];
        pdc3d_pkg::RegSmooth:  smooth_factor <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  pdc3d_pkg::state_t state, state_next;

  // working registers
  logic signed [32:0] perr [3];
  logic signed [32:0] verr [3];
  logic signed [31:0] vec [3];
  logic signed [31:0] prev_drive [3];
  logic               have_prev;
  logic [1:0]         axis;
  logic [6:0]         cnt;
  logic [65:0]        acc;      // product / square accumulator
  logic [65:0]        mcand;    // shifted multiplicand
  logic [32:0]        mplier;   // serial multiplier bits
  logic               neg;      // sign of current product
  logic signed [49:0] pterm;    // floored proportional term
  logic [65:0]        sumsq;
  logic               limited;
  logic [65:0]        rem;
  logic [33:0]        root;
  logic [63:0]        dnum;     // dividend shifted out
  logic [63:0]        drem;
  logic [63:0]        quot;
  logic               dneg;
  logic               out_full;

  logic               accept;
  assign accept = in_valid && !in_stall;
  assign in_stall = (state != pdc3d_pkg::ST_IDLE);

  // signed product finished, floored by 16
  logic signed [65:0] prod_s;
  logic signed [49:0] prod_fl;
  assign prod_s  = neg ? -$signed(acc) : $signed(acc);
  assign prod_fl = prod_s[65:16];

  logic signed [50:0] pdsum;
  assign pdsum = 51'(pterm) + 51'(prod_fl);

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    if (v > 51'sd2147483647) return 32'sh7fffffff;
    if (v < -51'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // magnitude of the current axis
  logic [31:0] vabs;
  assign vabs = vec[axis][31] ? 32'(-vec[axis]) : 32'(vec[axis]);

  // clamp test on the last max_magnitude square bit
  logic [65:0] mm_sq;
  logic        clamp_hit;
  assign mm_sq     = mplier[0] ? acc + mcand : acc;
  assign clamp_hit = (sumsq > mm_sq) && (sumsq > pdc3d_pkg::TinySq);

  // sqrt trial
  logic [65:0] sq_trial;
  logic [67:0] rem_sh;
  assign rem_sh   = {rem, 2'b00};
  assign sq_trial = {30'd0, root, 2'b01};

  // smoothing weight
  logic [16:0] w;
  assign w = (smooth_factor >= pdc3d_pkg::OneQ16) ? 17'd0 :
             17'(pdc3d_pkg::OneQ16 - smooth_factor);

  logic [64:0] drem_sh;
  assign drem_sh = {drem, dnum[63]};

  always_comb begin
    state_next = state;
    case (state)
      pdc3d_pkg::ST_IDLE:       if (accept) state_next = pdc3d_pkg::ST_MUL_P;
      pdc3d_pkg::ST_MUL_P:      if (cnt == 7'd32) state_next = pdc3d_pkg::ST_MUL_D;
      pdc3d_pkg::ST_MUL_D:      if (cnt == 7'd32) state_next = pdc3d_pkg::ST_SUM;
      pdc3d_pkg::ST_SUM:        state_next = (axis == 2'd2) ? pdc3d_pkg::ST_SQ
                                                            : pdc3d_pkg::ST_MUL_P;
      pdc3d_pkg::ST_SQ:         if (cnt == 7'd32 && axis == 2'd2)
                                  state_next = pdc3d_pkg::ST_TEST;
      pdc3d_pkg::ST_TEST:       if (cnt == 7'd31) state_next = clamp_hit ?
                                  pdc3d_pkg::ST_SQRT : pdc3d_pkg::ST_SMOOTH;
      pdc3d_pkg::ST_SQRT:       if (cnt == 7'd32) state_next = pdc3d_pkg::ST_SQRT_FIX;
      pdc3d_pkg::ST_SQRT_FIX:   if (cnt == 7'd33) state_next = pdc3d_pkg::ST_DIV;
      pdc3d_pkg::ST_DIV:        if (cnt == 7'd63) state_next = pdc3d_pkg::ST_DIV_END;
      pdc3d_pkg::ST_DIV_END:    state_next = (axis == 2'd2) ? pdc3d_pkg::ST_SMOOTH
                                                            : pdc3d_pkg::ST_DIV;
      pdc3d_pkg::ST_SMOOTH:     if (smooth_factor == '0 || !have_prev)
                                  state_next = pdc3d_pkg::ST_OUT;
                                else if (cnt == 7'd16)
                                  state_next = pdc3d_pkg::ST_SMOOTH_END;
      pdc3d_pkg::ST_SMOOTH_END: state_next = (axis == 2'd2) ? pdc3d_pkg::ST_OUT
                                                            : pdc3d_pkg::ST_SMOOTH;
      pdc3d_pkg::ST_OUT:        if (!out_full) state_next = pdc3d_pkg::ST_IDLE;
      default:                  state_next = pdc3d_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pdc3d_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      out_full <= 1'b0;
      for (int i = 0; i < 3; i++) prev_drive[i] <= '0;
    end else begin
      if (out_valid && !out_stall) out_full <= 1'b0;
      case (state)
        pdc3d_pkg::ST_IDLE: begin
          // capture errors and load the x proportional product
          if (accept) begin
            perr[0] <= 33'(tgt_pos_x) - 33'(cur_pos_x);
            perr[1] <= 33'(tgt_pos_y) - 33'(cur_pos_y);
            perr[2] <= 33'(tgt_pos_z) - 33'(cur_pos_z);
            verr[0] <= 33'(tgt_vel_x) - 33'(cur_vel_x);
            verr[1] <= 33'(tgt_vel_y) - 33'(cur_vel_y);
            verr[2] <= 33'(tgt_vel_z) - 33'(cur_vel_z);
            axis <= 2'd0;
            cnt <= '0;
            acc <= '0;
            limited <= 1'b0;
            sumsq <= '0;
            begin
              logic signed [32:0] e;
              e = 33'(tgt_pos_x) - 33'(cur_pos_x);
              mcand  <= 66'(e[32] ? 33'(-e) : e);
              mplier <= pos_gain[31] ? 33'(-33'(pos_gain)) : 33'(pos_gain);
              neg    <= e[32] ^ pos_gain[31];
            end
          end
        end
        pdc3d_pkg::ST_MUL_P, pdc3d_pkg::ST_MUL_D: begin
          // one multiplier bit per cycle
          if (mplier[0]) acc <= acc + mcand;
          mplier <= mplier >> 1;
          mcand  <= mcand << 1;
          cnt    <= cnt + 7'd1;
          if (cnt == 7'd32) begin
            cnt <= '0;
            if (state == pdc3d_pkg::ST_MUL_P) begin
              logic signed [65:0] ps;
              logic [65:0] a2;
              logic signed [32:0] e;
              a2 = mplier[0] ? acc + mcand : acc;
              ps = neg ? -$signed(a2) : $signed(a2);
              pterm <= ps[65:16];
              e = verr[axis];
              acc    <= '0;
              mcand  <= 66'(e[32] ? 33'(-e) : e);
              mplier <= vel_gain[31] ? 33'(-33'(vel_gain)) : 33'(vel_gain);
              neg    <= e[32] ^ vel_gain[31];
            end else begin
              if (mplier[0]) acc <= acc + mcand;
            end
          end
        end
        pdc3d_pkg::ST_SUM: begin
          // saturate the axis and set up the next one
          vec[axis] <= sat32(pdsum);
          cnt <= '0;
          acc <= '0;
          if (axis != 2'd2) begin
            logic signed [32:0] e;
            logic [1:0] nx;
            nx = axis + 2'd1;
            e = perr[nx];
            axis   <= nx;
            mcand  <= 66'(e[32] ? 33'(-e) : e);
            mplier <= pos_gain[31] ? 33'(-33'(pos_gain)) : 33'(pos_gain);
            neg    <= e[32] ^ pos_gain[31];
          end else begin
            axis <= 2'd0;
          end
        end
        pdc3d_pkg::ST_SQ: begin
          // square each axis magnitude, one bit per cycle
          if (cnt == 7'd0) begin
            mcand  <= 66'(vabs);
            mplier <= 33'(vabs);
            acc    <= '0;
            cnt    <= 7'd1;
          end else begin
            if (mplier[0]) acc <= acc + mcand;
            mplier <= mplier >> 1;
            mcand  <= mcand << 1;
            cnt    <= cnt + 7'd1;
            if (cnt == 7'd32) begin
              sumsq <= sumsq + (mplier[0] ? acc + mcand : acc);
              cnt   <= '0;
              if (axis != 2'd2) axis <= axis + 2'd1;
              else begin
                axis   <= 2'd0;
                mcand  <= 66'(max_magnitude);
                mplier <= 33'(max_magnitude);
                acc    <= '0;
              end
            end
          end
        end
        pdc3d_pkg::ST_TEST: begin
          // square max_magnitude serially, then compare
          if (mplier[0]) acc <= acc + mcand;
          mplier <= mplier >> 1;
          mcand  <= mcand << 1;
          cnt    <= cnt + 7'd1;
          if (cnt == 7'd31) begin
            limited <= clamp_hit;
            cnt  <= '0;
            rem  <= '0;
            root <= '0;
            acc  <= sumsq;
          end
        end
        pdc3d_pkg::ST_SQRT: begin
          // two radicand bits per cycle
          logic [65:0] r2;
          r2 = rem_sh[65:0] | 66'(acc[65:64]);
          acc <= acc << 2;
          if (r2 >= sq_trial) begin
            rem  <= r2 - sq_trial;
            root <= {root[32:0], 1'b1};
          end else begin
            rem  <= r2;
            root <= {root[32:0], 1'b0};
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'd32) begin
            // reload for root*root check via rem==0
            cnt <= 7'd33;
          end
        end
        pdc3d_pkg::ST_SQRT_FIX: begin
          // nonzero remainder means round up
          if (rem != '0) root <= root + 34'd1;
          axis <= 2'd0;
          cnt  <= '0;
          drem <= '0;
          begin
            logic [63:0] n;
            n = 64'(vabs) * 64'(max_magnitude);
            dnum <= n;
          end
          dneg <= vec[0][31];
        end
        pdc3d_pkg::ST_DIV: begin
          // one quotient bit per cycle
          dnum <= dnum << 1;
          if (drem_sh >= 65'(root)) begin
            drem <= 64'(drem_sh - 65'(root));
            quot <= {quot[62:0], 1'b1};
          end else begin
            drem <= drem_sh[63:0];
            quot <= {quot[62:0], 1'b0};
          end
          cnt <= cnt + 7'd1;
        end
        pdc3d_pkg::ST_DIV_END: begin
          vec[axis] <= dneg ? -$signed(quot[31:0]) : $signed(quot[31:0]);
          cnt  <= '0;
          drem <= '0;
          if (axis != 2'd2) begin
            logic [1:0] nx;
            logic [31:0] va;
            nx = axis + 2'd1;
            va = vec[nx][31] ? 32'(-vec[nx]) : 32'(vec[nx]);
            axis <= nx;
            dnum <= 64'(va) * 64'(max_magnitude);
            dneg <= vec[nx][31];
          end else begin
            axis <= 2'd0;
          end
        end
        pdc3d_pkg::ST_SMOOTH: begin
          // diff times weight, one weight bit per cycle
          if (cnt == 7'd0) begin
            logic signed [32:0] df;
            df = 33'(vec[axis]) - 33'(prev_drive[axis]);
            mcand  <= 66'(df[32] ? 33'(-df) : df);
            mplier <= 33'(w);
            neg    <= df[32];
            acc    <= '0;
            cnt    <= 7'd1;
          end else begin
            if (mplier[0]) acc <= acc + mcand;
            mplier <= mplier >> 1;
            mcand  <= mcand << 1;
            cnt    <= cnt + 7'd1;
          end
        end
        pdc3d_pkg::ST_SMOOTH_END: begin
          vec[axis] <= sat32(51'(prev_drive[axis]) + 51'(prod_fl));
          cnt <= '0;
          axis <= (axis == 2'd2) ? 2'd0 : axis + 2'd1;
        end
        pdc3d_pkg::ST_OUT: begin
          // hand the result to the output register
          if (!out_full) begin
            drive_x <= vec[0];
            drive_y <= vec[1];
            drive_z <= vec[2];
            was_limited <= limited;
            for (int i = 0; i < 3; i++) prev_drive[i] <= vec[i];
            have_prev <= 1'b1;
            out_full <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_full;

endmodule

FILE: design/pdc3d_checker.sv
`include "pd_controller_3d_clamped_smoothed_unit_macros.svh"
module pdc3d_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] drive_x,
  input logic        was_limited
);
  // a stalled result beat holds
  `PDC_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable({drive_x, was_limited}), "result dropped")
  // no result beat straight after an input beat
  `PDC_ASSERT_NEXT(a_lat, in_valid && !in_stall, !$rose(out_valid), "result too early")
  // a result beat carries known values
  `PDC_ASSERT_IMPL(a_known, out_valid, !$isunknown({drive_x, was_limited}), "unknown result")
endmodule

bind pd_controller_3d_clamped_smoothed_unit pdc3d_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .drive_x(drive_x),
  .was_limited(was_limited)
);
